// ===== src/assert_macros.svh =====
// assertion helpers used by the assertion checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle, off while reset is high
`define RAC_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// implication into the next cycle, off while reset is high
`define RAC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

// implication into the next cycle, also checked across reset
`define RAC_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== src/rac_pkg.sv =====
package rac_pkg;

   localparam int FIELD_BITS = 12;
   localparam int COLOR_BITS = 24;
   localparam int ALPHA_BITS = 9;
   localparam int CHAN_BITS  = 8;

   localparam logic [ALPHA_BITS-1:0] OPAQUE = 9'd256;

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_PIXEL = 1'b1;

   localparam logic ST_OK   = 1'b0;
   localparam logic ST_FULL = 1'b1;

   // item travelling down the cell chain
   typedef struct packed {
      logic                  valid;
      logic                  is_pixel;
      logic                  status;
      logic [FIELD_BITS-1:0] px;
      logic [FIELD_BITS-1:0] py;
      logic [COLOR_BITS-1:0] color;
   } tok_type;

   function automatic logic [CHAN_BITS-1:0] mix_channel(
      input logic [CHAN_BITS-1:0]  old_c,
      input logic [CHAN_BITS-1:0]  new_c,
      input logic [ALPHA_BITS-1:0] a
   );
      logic [16:0] sum;
      sum = {9'd0, old_c} * {8'd0, OPAQUE - a} + {9'd0, new_c} * {8'd0, a};
      return sum[15:8];
   endfunction

   function automatic logic [COLOR_BITS-1:0] blend_color(
      input logic [COLOR_BITS-1:0] bg,
      input logic [COLOR_BITS-1:0] fg,
      input logic [ALPHA_BITS-1:0] a
   );
      return {mix_channel(bg[23:16], fg[23:16], a),
              mix_channel(bg[15:8],  fg[15:8],  a),
              mix_channel(bg[7:0],   fg[7:0],   a)};
   endfunction

endpackage

// ===== src/rac_if.sv =====
interface rac_req_if;
   import rac_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  opcode;
   logic [FIELD_BITS-1:0] rect_x;
   logic [FIELD_BITS-1:0] rect_y;
   logic [FIELD_BITS-1:0] rect_w;
   logic [FIELD_BITS-1:0] rect_h;
   logic [COLOR_BITS-1:0] rect_color;
   logic [ALPHA_BITS-1:0] rect_opacity;
   logic [FIELD_BITS-1:0] pixel_x;
   logic [FIELD_BITS-1:0] pixel_y;
   logic [COLOR_BITS-1:0] pixel_color;

   modport source (
      output valid, opcode, rect_x, rect_y, rect_w, rect_h, rect_color, rect_opacity,
             pixel_x, pixel_y, pixel_color,
      input  ready
   );
   modport sink (
      input  valid, opcode, rect_x, rect_y, rect_w, rect_h, rect_color, rect_opacity,
             pixel_x, pixel_y, pixel_color,
      output ready
   );
endinterface

interface rac_rsp_if;
   import rac_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [COLOR_BITS-1:0] result_color;
   logic                  status;

   modport source (output valid, result_color, status, input ready);
   modport sink   (input valid, result_color, status, output ready);
endinterface

// ===== src/rac_cell.sv =====
module rac_cell #(
   parameter int INDEX    = 0,
   parameter int CNT_BITS = 5,
   parameter int CW       = 12
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           wr_en,
   input  logic [CW-1:0]                  wr_x,
   input  logic [CW-1:0]                  wr_y,
   input  logic [CW-1:0]                  wr_w,
   input  logic [CW-1:0]                  wr_h,
   input  logic [rac_pkg::COLOR_BITS-1:0] wr_color,
   input  logic [rac_pkg::ALPHA_BITS-1:0] wr_alpha,
   input  rac_pkg::tok_type               tok_prev,
   input  logic [CNT_BITS-1:0]            count_prev,
   output rac_pkg::tok_type               tok_next,
   output logic [CNT_BITS-1:0]            count_next
);
   import rac_pkg::*;

   logic [CW-1:0]         x_ff, y_ff, w_ff, h_ff;
   logic [COLOR_BITS-1:0] color_ff;
   logic [ALPHA_BITS-1:0] alpha_ff;
   tok_type               tok_ff, tok_in;
   logic [CNT_BITS-1:0]   count_ff;

   logic [CW-1:0] px, py;
   logic [CW:0]   x_end, y_end;
   logic          in_table, hit_x, hit_y, hit;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         x_ff     <= wr_x;
         y_ff     <= wr_y;
         w_ff     <= wr_w;
         h_ff     <= wr_h;
         color_ff <= wr_color;
         alpha_ff <= wr_alpha;
      end
   end

   assign px    = tok_prev.px[CW-1:0];
   assign py    = tok_prev.py[CW-1:0];
   // ends are one bit wider so a rectangle past the edge clips instead of wrapping
   assign x_end = {1'b0, x_ff} + {1'b0, w_ff};
   assign y_end = {1'b0, y_ff} + {1'b0, h_ff};
   assign hit_x = (px >= x_ff) && ({1'b0, px} < x_end);
   assign hit_y = (py >= y_ff) && ({1'b0, py} < y_end);
   // only rectangles stored before this pixel was taken may paint it
   assign in_table = count_prev > CNT_BITS'(INDEX);
   assign hit      = tok_prev.valid && tok_prev.is_pixel && in_table && hit_x && hit_y;

   always_comb begin
      tok_in = tok_prev;
      if (hit) begin
         tok_in.color = blend_color(tok_prev.color, color_ff, alpha_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (advance) begin
         tok_ff   <= tok_in;
         count_ff <= count_prev;
      end
   end

   assign tok_next   = tok_ff;
   assign count_next = count_ff;

endmodule

// ===== src/rectangle_alpha_compositor_core.sv =====
// Rectangle alpha compositor. An add item (opcode 0) stores one rectangle in the
// next free cell and answers status 0, or status 1 with color 0 when all MAX_RECTS
// cells are taken. A pixel item (opcode 1) runs down a chain of MAX_RECTS cells,
// one per table slot in table order; each cell blends its color over the
// pixel when it covers the coordinate (half-open, x <= px < x+w). Every item gives
// exactly one result, in order. One item is taken per clock as long as results are
// taken; a result comes out of the last of the MAX_RECTS cell registers, and a
// stalled result holds the whole chain.
module rectangle_alpha_compositor_core #(
   parameter int MAX_RECTS  = 16,
   parameter int COORD_BITS = 12
) (
   input logic          clock,
   input logic          reset,
   rac_req_if.sink      req_port,
   rac_rsp_if.source    rsp_port
);
   import rac_pkg::*;

   localparam int CNT_BITS = $clog2(MAX_RECTS + 1);
   localparam int CW       = (COORD_BITS < FIELD_BITS) ? COORD_BITS : FIELD_BITS;

   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  advance, accept, is_add, full, store;
   logic [ALPHA_BITS-1:0] alpha_sat;
   tok_type               chain_tok [0:MAX_RECTS];
   logic [CNT_BITS-1:0]   chain_cnt [0:MAX_RECTS];

   assign advance        = !rsp_port.valid || rsp_port.ready;
   assign req_port.ready = advance;
   assign accept         = req_port.valid && advance;
   assign is_add         = req_port.opcode == OP_ADD;
   assign full           = count_ff >= CNT_BITS'(MAX_RECTS);
   assign store          = accept && is_add && !full;
   assign alpha_sat      = (req_port.rect_opacity > OPAQUE) ? OPAQUE : req_port.rect_opacity;

   assign count_in = store ? count_ff + CNT_BITS'(1) : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_comb begin
      chain_tok[0].valid    = accept;
      chain_tok[0].is_pixel = req_port.opcode == OP_PIXEL;
      chain_tok[0].status   = (is_add && full) ? ST_FULL : ST_OK;
      chain_tok[0].px       = req_port.pixel_x;
      chain_tok[0].py       = req_port.pixel_y;
      chain_tok[0].color    = is_add ? '0 : req_port.pixel_color;
   end
   assign chain_cnt[0] = count_ff;

   for (genvar i = 0; i < MAX_RECTS; i++) begin : g_cell
      rac_cell #(
         .INDEX    (i),
         .CNT_BITS (CNT_BITS),
         .CW       (CW)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .wr_en      (store && (count_ff == CNT_BITS'(i))),
         .wr_x       (req_port.rect_x[CW-1:0]),
         .wr_y       (req_port.rect_y[CW-1:0]),
         .wr_w       (req_port.rect_w[CW-1:0]),
         .wr_h       (req_port.rect_h[CW-1:0]),
         .wr_color   (req_port.rect_color),
         .wr_alpha   (alpha_sat),
         .tok_prev   (chain_tok[i]),
         .count_prev (chain_cnt[i]),
         .tok_next   (chain_tok[i+1]),
         .count_next (chain_cnt[i+1])
      );
   end

   assign rsp_port.valid        = chain_tok[MAX_RECTS].valid;
   assign rsp_port.result_color = chain_tok[MAX_RECTS].color;
   assign rsp_port.status       = chain_tok[MAX_RECTS].status;

endmodule

// ===== src/rac_checker.sv =====
`include "assert_macros.svh"

module rac_assert_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [rac_pkg::COLOR_BITS-1:0] rsp_result_color,
   input logic                           rsp_status
);
   import rac_pkg::*;

   logic rsp_stall;

   assign rsp_stall = rsp_valid && !rsp_ready;

   // a stalled result holds until the transfer
   `RAC_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable({rsp_result_color, rsp_status}))

   // a stalled result stalls the input side too
   `RAC_ASSERT_IMPL(a_stall_backs_up, rsp_stall, !req_ready)

   // a dropped rectangle carries no color
   `RAC_ASSERT_IMPL(a_full_no_color, rsp_valid && (rsp_status == ST_FULL), rsp_result_color == '0)

   // reset empties the chain
   `RAC_ASSERT_NEXT_ALWAYS(a_reset_empty, reset, !rsp_valid)

endmodule

bind rectangle_alpha_compositor_core rac_assert_checker u_rac_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_port.valid),
   .req_ready        (req_port.ready),
   .rsp_valid        (rsp_port.valid),
   .rsp_ready        (rsp_port.ready),
   .rsp_result_color (rsp_port.result_color),
   .rsp_status       (rsp_port.status)
);

// ===== bench/rac_checker.sv =====
module rac_checker
   import rac_pkg::*;
#(
   parameter int MAX_RECTS = 16
) (
   input  logic clock,
   input  logic reset,
   rac_req_if   req_mon,
   rac_rsp_if   rsp_mon,
   output int   fail_count,
   output int   outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [COLOR_BITS-1:0] color;
      logic                  status;
   } outcome_t;

   // private copy of the rectangle table
   logic [FIELD_BITS-1:0] rect_left   [MAX_RECTS];
   logic [FIELD_BITS-1:0] rect_top    [MAX_RECTS];
   logic [FIELD_BITS-1:0] rect_width  [MAX_RECTS];
   logic [FIELD_BITS-1:0] rect_height [MAX_RECTS];
   logic [COLOR_BITS-1:0] rect_paint  [MAX_RECTS];
   logic [ALPHA_BITS-1:0] rect_alpha  [MAX_RECTS];
   int                    stored_rects = 0;

   outcome_t outcome_q[$];
   int       mismatch_total = 0;

   function automatic logic [CHAN_BITS-1:0] lay_channel(
      input logic [CHAN_BITS-1:0]  under,
      input logic [CHAN_BITS-1:0]  over,
      input logic [ALPHA_BITS-1:0] alpha
   );
      int unsigned acc;
      acc = under * (256 - alpha) + over * alpha;
      return CHAN_BITS'(acc >> 8);
   endfunction

   task automatic record_request();
      outcome_t              owed;
      logic [ALPHA_BITS-1:0] alpha;
      logic [CHAN_BITS-1:0]  red, green, blue;
      logic [FIELD_BITS-1:0] px, py;
      logic [FIELD_BITS:0]   right_end, bottom_end;
      logic [COLOR_BITS-1:0] paint;
      owed.color  = '0;
      owed.status = ST_OK;
      if (req_mon.opcode == OP_ADD) begin
         if (stored_rects >= MAX_RECTS) begin
            owed.status = ST_FULL;
         end else begin
            alpha = (req_mon.rect_opacity > OPAQUE) ? OPAQUE : req_mon.rect_opacity;
            rect_left[stored_rects]   = req_mon.rect_x;
            rect_top[stored_rects]    = req_mon.rect_y;
            rect_width[stored_rects]  = req_mon.rect_w;
            rect_height[stored_rects] = req_mon.rect_h;
            rect_paint[stored_rects]  = req_mon.rect_color;
            rect_alpha[stored_rects]  = alpha;
            stored_rects++;
         end
      end else begin
         px = req_mon.pixel_x;
         py = req_mon.pixel_y;
         {red, green, blue} = req_mon.pixel_color;
         for (int i = 0; i < stored_rects; i++) begin
            // one extra bit so a rectangle past the far edge clips instead of wrapping
            right_end  = {1'b0, rect_left[i]} + rect_width[i];
            bottom_end = {1'b0, rect_top[i]} + rect_height[i];
            if (px >= rect_left[i] && {1'b0, px} < right_end &&
                py >= rect_top[i] && {1'b0, py} < bottom_end) begin
               paint = rect_paint[i];
               red   = lay_channel(red,   paint[23:16], rect_alpha[i]);
               green = lay_channel(green, paint[15:8],  rect_alpha[i]);
               blue  = lay_channel(blue,  paint[7:0],   rect_alpha[i]);
            end
         end
         owed.color = {red, green, blue};
      end
      outcome_q.push_back(owed);
   endtask

   always @(posedge clock) begin
      outcome_t want;
      if (reset) begin
         stored_rects = 0;
         outcome_q.delete();
      end else begin
         if (req_mon.valid && req_mon.ready)
            record_request();
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (outcome_q.size() == 0) begin
               $error("result transfer with nothing expected: result_color %06h status %0b",
                      rsp_mon.result_color, rsp_mon.status);
               mismatch_total++;
            end else begin
               want = outcome_q.pop_front();
               if (rsp_mon.result_color !== want.color) begin
                  $error("result_color: expected %06h, got %06h",
                         want.color, rsp_mon.result_color);
                  mismatch_total++;
               end
               if (rsp_mon.status !== want.status) begin
                  $error("status: expected %0b, got %0b", want.status, rsp_mon.status);
                  mismatch_total++;
               end
            end
         end
      end
      fail_count  <= mismatch_total;
      outstanding <= outcome_q.size();
   end

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import rac_pkg::*;

   localparam int TABLE_DEPTH  = 16;
   localparam int HOLD_CYCLES  = 150;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 3 * TABLE_DEPTH + 8;

   typedef struct {
      logic                  opcode;
      logic [FIELD_BITS-1:0] rect_x;
      logic [FIELD_BITS-1:0] rect_y;
      logic [FIELD_BITS-1:0] rect_w;
      logic [FIELD_BITS-1:0] rect_h;
      logic [COLOR_BITS-1:0] rect_color;
      logic [ALPHA_BITS-1:0] rect_opacity;
      logic [FIELD_BITS-1:0] pixel_x;
      logic [FIELD_BITS-1:0] pixel_y;
      logic [COLOR_BITS-1:0] pixel_color;
   } req_item_type;

   logic clock;
   logic reset;
   int   fail_count;
   int   outstanding;
   int   sender_idle    = 0;
   int   receiver_stall = 0;
   bit   squeeze_rsp    = 1'b0;
   int   idle_cycles    = 0;

   // geometry of the rectangles that fit in the table, used to aim pixels at edges
   int unsigned aim_x[$], aim_y[$], aim_w[$], aim_h[$];

   rac_req_if req_bus ();
   rac_rsp_if rsp_bus ();

   rectangle_alpha_compositor_core #(
      .MAX_RECTS  (TABLE_DEPTH),
      .COORD_BITS (FIELD_BITS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   rac_checker #(
      .MAX_RECTS (TABLE_DEPTH)
   ) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic logic [FIELD_BITS-1:0] pick_coord();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return FIELD_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [FIELD_BITS-1:0] pick_size();
      case ($urandom_range(19))
         0, 1: return '0;
         2, 3: return '1;
         4, 5, 6, 7, 8, 9, 10: return FIELD_BITS'($urandom_range(64, 1));
         11, 12, 13, 14, 15, 16: return FIELD_BITS'($urandom_range(1024, 65));
         default: return FIELD_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [ALPHA_BITS-1:0] pick_alpha();
      case ($urandom_range(9))
         0, 1: return OPAQUE;
         2: return '0;
         3: return ALPHA_BITS'($urandom_range(511, 257));
         default: return ALPHA_BITS'($urandom_range(255, 1));
      endcase
   endfunction

   function automatic logic [COLOR_BITS-1:0] pick_color();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return COLOR_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [FIELD_BITS-1:0] near_edge(input int unsigned lo,
                                                       input int unsigned len);
      case ($urandom_range(4))
         0: return FIELD_BITS'(lo - 1);
         1: return FIELD_BITS'(lo);
         2: return FIELD_BITS'(lo + len - 1);
         3: return FIELD_BITS'(lo + len);
         default: return FIELD_BITS'(lo + $urandom_range(len));
      endcase
   endfunction

   // fields that the opcode does not use still carry random bits
   function automatic req_item_type noise_item();
      req_item_type it;
      it.opcode       = OP_PIXEL;
      it.rect_x       = FIELD_BITS'($urandom);
      it.rect_y       = FIELD_BITS'($urandom);
      it.rect_w       = FIELD_BITS'($urandom);
      it.rect_h       = FIELD_BITS'($urandom);
      it.rect_color   = COLOR_BITS'($urandom);
      it.rect_opacity = ALPHA_BITS'($urandom_range(511));
      it.pixel_x      = FIELD_BITS'($urandom);
      it.pixel_y      = FIELD_BITS'($urandom);
      it.pixel_color  = COLOR_BITS'($urandom);
      return it;
   endfunction

   task automatic put_payload(input req_item_type it);
      req_bus.opcode       <= it.opcode;
      req_bus.rect_x       <= it.rect_x;
      req_bus.rect_y       <= it.rect_y;
      req_bus.rect_w       <= it.rect_w;
      req_bus.rect_h       <= it.rect_h;
      req_bus.rect_color   <= it.rect_color;
      req_bus.rect_opacity <= it.rect_opacity;
      req_bus.pixel_x      <= it.pixel_x;
      req_bus.pixel_y      <= it.pixel_y;
      req_bus.pixel_color  <= it.pixel_color;
   endtask

   task automatic send(input req_item_type it);
      while ($urandom_range(99) < sender_idle) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      put_payload(it);
      if (it.opcode == OP_ADD && aim_x.size() < TABLE_DEPTH) begin
         aim_x.push_back(it.rect_x);
         aim_y.push_back(it.rect_y);
         aim_w.push_back(it.rect_w);
         aim_h.push_back(it.rect_h);
      end
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic add_rect(input int unsigned x, input int unsigned y,
                           input int unsigned w, input int unsigned h,
                           input logic [COLOR_BITS-1:0] color,
                           input logic [ALPHA_BITS-1:0] alpha);
      req_item_type it;
      it              = noise_item();
      it.opcode       = OP_ADD;
      it.rect_x       = FIELD_BITS'(x);
      it.rect_y       = FIELD_BITS'(y);
      it.rect_w       = FIELD_BITS'(w);
      it.rect_h       = FIELD_BITS'(h);
      it.rect_color   = color;
      it.rect_opacity = alpha;
      send(it);
   endtask

   task automatic shade(input int unsigned px, input int unsigned py,
                        input logic [COLOR_BITS-1:0] bg);
      req_item_type it;
      it             = noise_item();
      it.opcode      = OP_PIXEL;
      it.pixel_x     = FIELD_BITS'(px);
      it.pixel_y     = FIELD_BITS'(py);
      it.pixel_color = bg;
      send(it);
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
      req_item_type it;
      int           k;
      sender_idle    = idle_pct;
      receiver_stall = stall_pct;
      repeat (count) begin
         it = noise_item();
         if ($urandom_range(99) < 12) begin
            it.opcode       = OP_ADD;
            it.rect_x       = pick_coord();
            it.rect_y       = pick_coord();
            it.rect_w       = pick_size();
            it.rect_h       = pick_size();
            it.rect_color   = pick_color();
            it.rect_opacity = pick_alpha();
         end else begin
            it.opcode      = OP_PIXEL;
            it.pixel_color = pick_color();
            if (aim_x.size() != 0 && $urandom_range(99) < 70) begin
               k = $urandom_range(aim_x.size() - 1);
               it.pixel_x = near_edge(aim_x[k], aim_w[k]);
               it.pixel_y = near_edge(aim_y[k], aim_h[k]);
            end else begin
               it.pixel_x = pick_coord();
               it.pixel_y = pick_coord();
            end
         end
         send(it);
      end
   endtask

   // result side: random stalls, or one long hold-off when asked
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (squeeze_rsp) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            squeeze_rsp = 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= receiver_stall);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      put_payload('{default: '0});
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty table passes the background through
      shade(0, 0, 24'h000000);
      add_rect(0, 0, 4095, 4095, 24'hffffff, 9'd128);
      shade(0, 0, 24'h000000);
      // last column and row lie outside a half-open extent
      shade(4095, 4095, 24'h123456);
      // reaches past the far edge, opacity saturates
      add_rect(4000, 4000, 4095, 4095, 24'h000000, 9'd511);
      shade(4095, 4095, 24'hffffff);
      add_rect(100, 100, 0, 50, 24'hff0000, OPAQUE);
      add_rect(100, 100, 50, 0, 24'h00ff00, OPAQUE);
      shade(100, 100, 24'h0000ff);
      add_rect(200, 300, 16, 16, 24'h0000ff, 9'd0);
      add_rect(200, 300, 16, 16, 24'hff0000, OPAQUE);
      shade(200, 300, pick_color());
      shade(215, 315, pick_color());
      add_rect(4095, 4095, 1, 1, 24'h00ff00, OPAQUE);
      shade(4095, 4095, 24'h000000);
      while (aim_x.size() < TABLE_DEPTH)
         add_rect(pick_coord(), pick_coord(), pick_size(), pick_size(), pick_color(),
                  pick_alpha());
      // table full: this one is dropped
      add_rect(10, 10, 20, 20, 24'hffffff, OPAQUE);
      shade(4095, 0, 24'h00ff00);

      run_phase(0, 0, 320);
      run_phase(76, 0, 320);
      run_phase(0, 76, 320);
      run_phase(35, 35, 320);
      // hold results back while items keep coming so the chain backs up
      squeeze_rsp = 1'b1;
      run_phase(0, 0, 60);

      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
